@@ sv/lkv_pkg.sv @@
// lkv_pkg: sizes, command and status types for the LRU key-value cache.
// Used by lkv_ctrl, lkv_dp and lru_key_value_cache. No dependencies.
package lkv_pkg;

    localparam int SLOTS       = 64;
    localparam int KEY_WIDTH   = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int CAP_W       = 7;
    localparam int CAP_RESET   = 64;
    localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W       = $clog2(SLOTS + 1);
    localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SCAN,
        OP_SEL_HIT,
        OP_SEL_EVICT,
        OP_SEL_FREE,
        OP_LINK_WR,
        OP_PUSH,
        OP_INSERT,
        OP_RESP
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic             scan_done;
        logic             found;
        logic             is_get;
        logic             evicting;
        logic             evict_need;
        logic             free_found;
        logic             out_free;
        logic [CNT_W-1:0] entry_count;
    } status_t;

endpackage

@@ sv/lkv_ram.sv @@
// lkv_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module lkv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/lkv_ctrl.sv @@
// lkv_ctrl: request sequencer of the LRU key-value cache.
// Depends on lkv_pkg; drives lkv_dp through cmd_t, reads status_t.
module lkv_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  lkv_pkg::status_t st,
    output lkv_pkg::cmd_t    cmd
);
    import lkv_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_LINK_RD,
        S_LINK_WR,
        S_PUSH,
        S_INSERT,
        S_RESP
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.op = OP_SCAN;
                if (st.scan_done)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (st.found)
                begin
                    cmd.op     = OP_SEL_HIT;
                    state_next = S_LINK_RD;
                end
                else if (st.is_get)
                begin
                    state_next = S_RESP;
                end
                else if (st.evict_need)
                begin
                    cmd.op     = OP_SEL_EVICT;
                    state_next = S_LINK_RD;
                end
                else if (st.free_found)
                begin
                    cmd.op     = OP_SEL_FREE;
                    state_next = S_INSERT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_LINK_RD:
            begin
                state_next = S_LINK_WR;
            end
            S_LINK_WR:
            begin
                cmd.op     = OP_LINK_WR;
                state_next = st.evicting ? S_INSERT : S_PUSH;
            end
            S_PUSH:
            begin
                cmd.op     = OP_PUSH;
                state_next = st.is_get ? S_RESP : S_IDLE;
            end
            S_INSERT:
            begin
                cmd.op     = OP_INSERT;
                state_next = S_IDLE;
            end
            S_RESP:
            begin
                if (st.out_free)
                begin
                    cmd.op     = OP_RESP;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ sv/lkv_dp.sv @@
// lkv_dp: slot memories, recency links, key scan and result register.
// Depends on lkv_pkg and lkv_ram; commanded by lkv_ctrl.
module lkv_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  lkv_pkg::cmd_t                  cmd,
    output lkv_pkg::status_t               st,
    input  logic                           cfg_we,
    input  logic [lkv_pkg::CAP_W-1:0]      cfg_wdata,
    input  logic                           in_cmd,
    input  logic [lkv_pkg::KEY_WIDTH-1:0]  in_key,
    input  logic [lkv_pkg::VALUE_WIDTH-1:0] in_value,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           out_hit,
    output logic [lkv_pkg::VALUE_WIDTH-1:0] out_value
);
    import lkv_pkg::*;

    logic [CAP_W-1:0]       cap_reg;
    logic                   get_reg;
    logic [KEY_WIDTH-1:0]   key_reg;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic [CNT_W-1:0]       scan_idx_reg;
    logic                   stage_vld_reg;
    logic [IDX_W-1:0]       stage_idx_reg;
    logic                   found_reg;
    logic [IDX_W-1:0]       fslot_reg;
    logic                   free_found_reg;
    logic [IDX_W-1:0]       free_idx_reg;
    logic [IDX_W-1:0]       s_reg;
    logic [IDX_W-1:0]       ins_reg;
    logic                   skip_reg;
    logic                   evict_reg;
    logic [VALUE_WIDTH-1:0] val_reg;
    logic [SLOTS-1:0]       valid_reg;
    logic [IDX_W-1:0]       newest_reg;
    logic [IDX_W-1:0]       oldest_reg;
    logic [CNT_W-1:0]       count_reg;
    logic                   out_valid_reg;
    logic                   out_hit_reg;
    logic [VALUE_WIDTH-1:0] out_value_reg;

    logic [KEY_WIDTH-1:0]   key_rdata;
    logic [VALUE_WIDTH-1:0] val_rdata;
    logic [IDX_W-1:0]       newer_rdata;
    logic [IDX_W-1:0]       older_rdata;

    logic                   key_we;
    logic                   val_we;
    logic [IDX_W-1:0]       val_waddr;
    logic                   older_we;
    logic [IDX_W-1:0]       older_waddr;
    logic [IDX_W-1:0]       older_wdata;
    logic                   newer_we;
    logic [IDX_W-1:0]       newer_waddr;
    logic [IDX_W-1:0]       newer_wdata;

    logic [CMP_W-1:0]       cap_ext;
    logic [CMP_W-1:0]       cap_eff;
    logic                   scan_issue;
    logic                   stage_match;
    logic                   stage_free;
    logic [IDX_W-1:0]       nw_eff;
    logic [IDX_W-1:0]       evict_slot;
    logic                   empty;

    assign cap_ext    = CMP_W'(cap_reg);
    assign cap_eff    = (cap_ext == '0) ? CMP_W'(1)
                      : (cap_ext > CMP_W'(SLOTS)) ? CMP_W'(SLOTS) : cap_ext;
    assign scan_issue = (scan_idx_reg < CNT_W'(SLOTS));
    assign stage_match = stage_vld_reg && valid_reg[stage_idx_reg]
                       && (key_rdata == key_reg);
    assign stage_free  = stage_vld_reg && !valid_reg[stage_idx_reg];
    assign nw_eff      = (s_reg == newest_reg) ? s_reg : newer_rdata;
    assign evict_slot  = (!free_found_reg || (s_reg < free_idx_reg)) ? s_reg : free_idx_reg;
    assign empty       = (count_reg == '0);

    assign st.scan_done   = stage_vld_reg && (stage_idx_reg == IDX_W'(SLOTS - 1));
    assign st.found       = found_reg;
    assign st.is_get      = get_reg;
    assign st.evicting    = evict_reg;
    assign st.evict_need  = (CMP_W'(count_reg) >= cap_eff) && !empty;
    assign st.free_found  = free_found_reg;
    assign st.out_free    = !out_valid_reg || out_ready;
    assign st.entry_count = count_reg;

    assign out_valid = out_valid_reg;
    assign out_hit   = out_hit_reg;
    assign out_value = out_value_reg;

    always_comb
    begin
        key_we      = (cmd.op == OP_INSERT);
        val_we      = 1'b0;
        val_waddr   = s_reg;
        older_we    = 1'b0;
        older_waddr = nw_eff;
        older_wdata = older_rdata;
        newer_we    = 1'b0;
        newer_waddr = older_rdata;
        newer_wdata = nw_eff;
        case (cmd.op)
            OP_LINK_WR:
            begin
                if (!skip_reg)
                begin
                    older_we = (s_reg != newest_reg);
                    newer_we = (s_reg != oldest_reg);
                end
            end
            OP_PUSH:
            begin
                val_we = !get_reg;
                if (!skip_reg)
                begin
                    older_we    = 1'b1;
                    older_waddr = s_reg;
                    older_wdata = newest_reg;
                    newer_we    = 1'b1;
                    newer_waddr = newest_reg;
                    newer_wdata = s_reg;
                end
            end
            OP_INSERT:
            begin
                val_we      = 1'b1;
                val_waddr   = ins_reg;
                older_we    = !empty;
                older_waddr = ins_reg;
                older_wdata = newest_reg;
                newer_we    = !empty;
                newer_waddr = newest_reg;
                newer_wdata = ins_reg;
            end
            default:
            begin
            end
        endcase
    end

    lkv_ram #(.WIDTH(KEY_WIDTH), .DEPTH(SLOTS)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (ins_reg),
        .wdata (key_reg),
        .raddr (scan_idx_reg[IDX_W-1:0]),
        .rdata (key_rdata)
    );

    lkv_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(SLOTS)) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (value_reg),
        .raddr (s_reg),
        .rdata (val_rdata)
    );

    lkv_ram #(.WIDTH(IDX_W), .DEPTH(SLOTS)) u_newer_ram (
        .clk   (clk),
        .we    (newer_we),
        .waddr (newer_waddr),
        .wdata (newer_wdata),
        .raddr (s_reg),
        .rdata (newer_rdata)
    );

    lkv_ram #(.WIDTH(IDX_W), .DEPTH(SLOTS)) u_older_ram (
        .clk   (clk),
        .we    (older_we),
        .waddr (older_waddr),
        .wdata (older_wdata),
        .raddr (s_reg),
        .rdata (older_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg        <= CAP_W'(CAP_RESET);
            scan_idx_reg   <= '0;
            stage_vld_reg  <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            skip_reg       <= 1'b0;
            evict_reg      <= 1'b0;
            valid_reg      <= '0;
            newest_reg     <= '0;
            oldest_reg     <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if (out_valid_reg && out_ready && (cmd.op != OP_RESP))
            begin
                out_valid_reg <= 1'b0;
            end
            case (cmd.op)
                OP_LOAD:
                begin
                    get_reg        <= !in_cmd;
                    key_reg        <= in_key;
                    value_reg      <= in_value;
                    scan_idx_reg   <= '0;
                    stage_vld_reg  <= 1'b0;
                    found_reg      <= 1'b0;
                    free_found_reg <= 1'b0;
                    evict_reg      <= 1'b0;
                    skip_reg       <= 1'b0;
                end
                OP_SCAN:
                begin
                    stage_vld_reg <= scan_issue;
                    stage_idx_reg <= scan_idx_reg[IDX_W-1:0];
                    if (scan_issue)
                    begin
                        scan_idx_reg <= scan_idx_reg + CNT_W'(1);
                    end
                    if (stage_match && !found_reg)
                    begin
                        found_reg <= 1'b1;
                        fslot_reg <= stage_idx_reg;
                    end
                    if (stage_free && !free_found_reg)
                    begin
                        free_found_reg <= 1'b1;
                        free_idx_reg   <= stage_idx_reg;
                    end
                end
                OP_SEL_HIT:
                begin
                    s_reg    <= fslot_reg;
                    skip_reg <= (fslot_reg == newest_reg);
                end
                OP_SEL_EVICT:
                begin
                    s_reg     <= oldest_reg;
                    evict_reg <= 1'b1;
                end
                OP_SEL_FREE:
                begin
                    ins_reg <= free_idx_reg;
                end
                OP_LINK_WR:
                begin
                    val_reg <= val_rdata;
                    if (!skip_reg)
                    begin
                        if (s_reg == newest_reg)
                        begin
                            newest_reg <= older_rdata;
                        end
                        if (s_reg == oldest_reg)
                        begin
                            oldest_reg <= nw_eff;
                        end
                    end
                    if (evict_reg)
                    begin
                        valid_reg[s_reg] <= 1'b0;
                        count_reg        <= count_reg - CNT_W'(1);
                        ins_reg          <= evict_slot;
                    end
                end
                OP_PUSH:
                begin
                    if (!skip_reg)
                    begin
                        newest_reg <= s_reg;
                    end
                end
                OP_INSERT:
                begin
                    valid_reg[ins_reg] <= 1'b1;
                    count_reg          <= count_reg + CNT_W'(1);
                    newest_reg         <= ins_reg;
                    if (empty)
                    begin
                        oldest_reg <= ins_reg;
                    end
                end
                OP_RESP:
                begin
                    out_valid_reg <= 1'b1;
                    out_hit_reg   <= found_reg;
                    out_value_reg <= found_reg ? val_reg : '0;
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

@@ sv/lru_key_value_cache.sv @@
// lru_key_value_cache: top level of the LRU key-value cache.
// Depends on lkv_pkg, lkv_ctrl, lkv_dp (which uses lkv_ram).
//
//  channel   dir  signals                     word
//  s_        in   s_tvalid/s_tready/...       tdata: key, value; tuser: cmd
//  m_        out  m_tvalid/m_tready/...       tdata: read_value; tuser: hit
//  cfg_      in   cfg_we, cfg_wdata           capacity_limit
//
// Each word runs from acceptance to the next ready through a load step, a
// key scan through the key RAM read port, a decide step, then a link
// read-modify-write, insert or result. One word is in work at a time; a get
// result waits in the output register and the next word is accepted
// meanwhile. A result step stalls while the previous result is still
// waiting. Reset clears valid bits at once.
module lru_key_value_cache (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [15:0] key, [47:16] value
    input  logic [0:0]  s_tuser,   // [0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] read_value
    output logic [0:0]  m_tuser,   // [0] hit
    input  logic        cfg_we,
    input  logic [lkv_pkg::CAP_W-1:0] cfg_wdata
);
    import lkv_pkg::*;

    cmd_t    cmd;
    status_t st;

    lkv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    lkv_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_cmd    (s_tuser[0]),
        .in_key    (s_tdata[15:0]),
        .in_value  (s_tdata[47:16]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_hit   (m_tuser[0]),
        .out_value (m_tdata)
    );

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        st.entry_count <= CNT_W'(SLOTS))
        else $error("entry count above slot count");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second word accepted during work");

    a_resp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(cmd.op == OP_RESP))
        else $error("result shown without response step");
`endif

endmodule
